### hw/rtl/sm4_block_cipher_ecb_assert.svh
// Assertion macros for the SM4 ECB block.
`ifndef SM4_BLOCK_CIPHER_ECB_ASSERT_SVH
`define SM4_BLOCK_CIPHER_ECB_ASSERT_SVH

// Implication checked in the same cycle, disabled in reset.
`define SM4_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sm4 assertion failed");

// Implication checked in the following cycle, disabled in reset.
`define SM4_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sm4 assertion failed");

`endif

### hw/rtl/sm4_pkg.sv
// Shared types, constants and round functions for the SM4 block.
package sm4_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned NumRounds = 32;

  // Config register indexes
  localparam logic [2:0] RegKey0    = 3'd0;
  localparam logic [2:0] RegKey3    = 3'd3;
  localparam logic [2:0] RegDecrypt = 3'd4;

  localparam word_t FK [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Byte-wise S-box
  function automatic word_t tau(word_t a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  // Data round transform T = L(tau(a))
  function automatic word_t t_data(word_t a);
    word_t b;
    b = tau(a);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  // Key schedule transform T' = L'(tau(a))
  function automatic word_t t_key(word_t a);
    word_t b;
    b = tau(a);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // CK constant: byte j of word i is (4i+j)*7 mod 256
  function automatic word_t ck_word(logic [4:0] i);
    word_t w;
    logic [7:0] b;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      b = 8'({1'b0, i, j[1:0]}) * 8'd7;
      w = {w[23:0], b};
    end
    return w;
  endfunction

endpackage

### hw/rtl/sm4_cell.sv
// One SM4 round cell: a pipeline stage holding the four-word round state.
module sm4_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  sm4_pkg::word_t x_i [4],
  input  logic          last_i,
  input  sm4_pkg::word_t rk_i,
  output logic          valid_o,
  output sm4_pkg::word_t x_o [4],
  output logic          last_o
);

  logic           valid_q;
  sm4_pkg::word_t x_q [4];
  logic           last_q;
  sm4_pkg::word_t new_w;

  // X[i+4] = X[i] ^ T(X[i+1] ^ X[i+2] ^ X[i+3] ^ rk)
  assign new_w = x_i[0] ^ sm4_pkg::t_data(x_i[1] ^ x_i[2] ^ x_i[3] ^ rk_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // State shifts down one word per round
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= x_i[1];
      x_q[1] <= x_i[2];
      x_q[2] <= x_i[3];
      x_q[3] <= new_w;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign last_o  = last_q;

endmodule

### hw/rtl/sm4_kexp.sv
// SM4 key schedule: one round key per cycle into a 32-entry key register file.
module sm4_kexp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  sm4_pkg::word_t key_i [4],
  output logic           busy_o,
  output sm4_pkg::word_t rk_o [sm4_pkg::NumRounds]
);

  logic           run_q;
  logic [4:0]     cnt_q;
  sm4_pkg::word_t k_q [4];
  sm4_pkg::word_t rk_q [sm4_pkg::NumRounds];
  sm4_pkg::word_t k_new;

  assign k_new = k_q[0] ^ sm4_pkg::t_key(k_q[1] ^ k_q[2] ^ k_q[3] ^ sm4_pkg::ck_word(cnt_q));

  // Control: start restarts the schedule from round 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(sm4_pkg::NumRounds - 1)) begin
        run_q <= 1'b0;
      end
    end
  end

  // Key state and round key file
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < 4; i++) begin
        k_q[i] <= key_i[i] ^ sm4_pkg::FK[i];
      end
    end else if (run_q) begin
      k_q[0] <= k_q[1];
      k_q[1] <= k_q[2];
      k_q[2] <= k_q[3];
      k_q[3] <= k_new;
      rk_q[cnt_q] <= k_new;
    end
  end

  assign busy_o = start_i | run_q;
  assign rk_o   = rk_q;

endmodule

### hw/rtl/sm4_block_cipher_ecb.sv
// SM4 ECB cipher top level: config registers, key schedule and 32-cell round chain.
//
// Input channel: block_word0..3 plus last_block, taken when in_valid_i is high
// and in_stall_o is low. Output channel: out_word0..3 (X35..X32) plus last_out,
// taken when out_valid_o is high and out_stall_i is low.
// The datapath is a chain of 32 round cells, one register each; one block
// is taken per cycle while in_stall_o is low. When the receiver stalls with
// a result waiting, the whole chain freezes and in_stall_o rises in the same
// cycle; the result holds until taken.
// Config: cfg_we_i writes register cfg_idx_i (0..3 key words, 4 decrypt mode).
// A key word write restarts the key schedule, which builds one round key per
// cycle; in_stall_o stays high while it runs. After reset the schedule runs
// for the all-zero key, so input is held off until it completes. The user
// must make writes only while no block is in flight; the block does not enforce this.
`include "sm4_block_cipher_ecb_assert.svh"

module sm4_block_cipher_ecb (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] block_word0_i,
  input  logic [31:0] block_word1_i,
  input  logic [31:0] block_word2_i,
  input  logic [31:0] block_word3_i,
  input  logic        last_block_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_word0_o,
  output logic [31:0] out_word1_o,
  output logic [31:0] out_word2_o,
  output logic [31:0] out_word3_o,
  output logic        last_out_o
);

  localparam int unsigned N = sm4_pkg::NumRounds;

  sm4_pkg::word_t key_q [4];
  logic           decrypt_q;
  logic           start_q;
  logic           key_wr;
  logic           kbusy;
  logic           en;
  sm4_pkg::word_t rk [N];
  sm4_pkg::word_t rk_sel [N];

  logic           st_v [N+1];
  logic           st_l [N+1];
  sm4_pkg::word_t st_x [N+1][4];

  // Config registers
  assign key_wr = cfg_we_i && (cfg_idx_i <= sm4_pkg::RegKey3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        key_q[i] <= '0;
      end
      decrypt_q <= 1'b0;
      start_q   <= 1'b1;
    end else begin
      start_q <= key_wr;
      if (key_wr) begin
        key_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == sm4_pkg::RegDecrypt) begin
        decrypt_q <= cfg_wdata_i[0];
      end
    end
  end

  sm4_kexp u_kexp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .key_i   (key_q),
    .busy_o  (kbusy),
    .rk_o    (rk)
  );

  // Chain advances unless a finished result is being held
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en || kbusy;

  assign st_v[0]    = in_valid_i && !in_stall_o;
  assign st_l[0]    = last_block_i;
  assign st_x[0][0] = block_word0_i;
  assign st_x[0][1] = block_word1_i;
  assign st_x[0][2] = block_word2_i;
  assign st_x[0][3] = block_word3_i;

  // Round cells, key order reversed for decryption
  for (genvar g = 0; g < N; g++) begin : g_cell
    assign rk_sel[g] = decrypt_q ? rk[N-1-g] : rk[g];

    sm4_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (st_v[g]),
      .x_i     (st_x[g]),
      .last_i  (st_l[g]),
      .rk_i    (rk_sel[g]),
      .valid_o (st_v[g+1]),
      .x_o     (st_x[g+1]),
      .last_o  (st_l[g+1])
    );
  end

  // Result is the final state in reversed word order
  assign out_valid_o = st_v[N];
  assign out_word0_o = st_x[N][3];
  assign out_word1_o = st_x[N][2];
  assign out_word2_o = st_x[N][1];
  assign out_word3_o = st_x[N][0];
  assign last_out_o  = st_l[N];

  // No block enters while round keys are being rebuilt
  `SM4_ASSERT_IMP(a_no_accept_busy, in_valid_i && !in_stall_o, !kbusy)
  // A held result freezes the input side
  `SM4_ASSERT_IMP(a_hold_blocks_input, out_valid_o && out_stall_i, in_stall_o)
  // A key word write always starts the schedule
  `SM4_ASSERT_NEXT(a_key_write_busy, key_wr, kbusy && in_stall_o)

endmodule
